>>> sv/gsc_pkg.sv
`timescale 1ns / 1ps

package gsc_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int IDX_W           = 5;
    localparam int TAB_ENTRIES     = 32;

    localparam logic [IDX_W-1:0] STEP_UP_MAX   = 5'd21;
    localparam logic [IDX_W-1:0] STEP_DOWN_MIN = 5'd5;
    localparam logic [1:0]       FRONT_TOP     = 2'd3;
    localparam logic [2:0]       REAR_TOP      = 3'd7;
    localparam logic [1:0]       FRONT_BOTTOM  = 2'd1;
    localparam logic [2:0]       REAR_BOTTOM   = 3'd1;
    localparam logic [1:0]       HILL_FRONT    = 2'd1;
    localparam logic [2:0]       HILL_REAR     = 3'd6;

    localparam logic [1:0] INIT_FRONT_RST = 2'd1;
    localparam logic [2:0] INIT_REAR_RST  = 3'd6;
    localparam logic [7:0] MAN_MIN_RST    = 8'd24;
    localparam logic [7:0] AUTO_MIN_RST   = 8'd48;

    // Gear tables, entry 0 at the low end of the packed vector.
    localparam logic [TAB_ENTRIES-1:0][1:0] FRONT_TAB =
        {{17{2'd3}}, {8{2'd2}}, {7{2'd1}}};
    localparam logic [TAB_ENTRIES-1:0][2:0] REAR_TAB =
        {{12{3'd1}}, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd3,
         3'd4, 3'd5, 3'd6, 3'd6, 3'd5, {6{3'd6}}};

    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_FRONT_UP   = 3'd1,
        OP_FRONT_DOWN = 3'd2,
        OP_REAR_UP    = 3'd3,
        OP_REAR_DOWN  = 3'd4,
        OP_SHUTDOWN   = 3'd5,
        OP_MODE       = 3'd6,
        OP_HILL       = 3'd7
    } gsc_op_t;

    typedef enum logic [1:0] {
        CFG_INIT_FRONT = 2'd0,
        CFG_INIT_REAR  = 2'd1,
        CFG_MAN_MIN    = 2'd2,
        CFG_AUTO_MIN   = 2'd3
    } gsc_cfg_idx_t;

    typedef struct packed {
        logic [1:0] init_front;
        logic [2:0] init_rear;
        logic [7:0] man_min;
        logic [7:0] auto_min;
    } gsc_cfg_t;

    typedef struct packed {
        logic             halted;
        logic             mode_auto;
        logic             hill;
        logic             warning;
        logic             pending;
        logic [7:0]       tick;
        logic [IDX_W-1:0] index;
        logic [1:0]       front;
        logic [2:0]       rear;
    } gsc_state_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] speed;
        logic [7:0] cadence;
        logic [7:0] tire_ticks;
        logic       new_data;
    } gsc_item_t;

endpackage

>>> sv/gsc_step.sv
`timescale 1ns / 1ps

module gsc_step #(
    parameter int TABLE_DEPTH = gsc_pkg::TABLE_DEPTH_DEF
) (
    input  gsc_pkg::gsc_state_t cur_i,
    input  gsc_pkg::gsc_cfg_t   cfg_i,
    input  gsc_pkg::gsc_item_t  item_i,
    output gsc_pkg::gsc_state_t nxt_o,
    output logic                shifted_o,
    output logic                store_gears_o
);
    import gsc_pkg::*;

    localparam int IDX_LIM_INT = (TABLE_DEPTH - 1 > 31) ? 31 : TABLE_DEPTH - 1;
    localparam logic [IDX_W-1:0] IDX_LIM = IDX_W'(IDX_LIM_INT);

    gsc_op_t          op;
    logic             ok;
    logic             act;
    logic             run_auto;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_sat;
    gsc_state_t       s;

    assign op      = gsc_op_t'(item_i.opcode);
    assign idx_sat = (item_i.tire_ticks > {3'd0, IDX_LIM}) ? IDX_LIM : item_i.tire_ticks[IDX_W-1:0];

    always_comb begin
        s             = cur_i;
        store_gears_o = 1'b0;
        run_auto      = 1'b0;
        ok            = (item_i.speed != 8'd0) && (item_i.cadence > cfg_i.man_min);
        act           = 1'b0;
        idx_a         = cur_i.index;
        idx_b         = cur_i.index;

        if (!cur_i.halted) begin
            if (item_i.new_data) begin
                s.pending = 1'b1;
            end
            if (op == OP_SHUTDOWN) begin
                s.halted      = 1'b1;
                store_gears_o = 1'b1;
            end else if (!cur_i.mode_auto) begin
                unique case (op)
                    OP_FRONT_UP:   act = cur_i.front != FRONT_TOP;
                    OP_FRONT_DOWN: act = cur_i.front != FRONT_BOTTOM;
                    OP_REAR_UP:    act = cur_i.rear != REAR_TOP;
                    OP_REAR_DOWN:  act = cur_i.rear != REAR_BOTTOM;
                    default:       act = 1'b0;
                endcase
                if (act) begin
                    s.warning = !ok;
                    if (ok) begin
                        unique case (op)
                            OP_FRONT_UP:   s.front = cur_i.front + 2'd1;
                            OP_FRONT_DOWN: s.front = cur_i.front - 2'd1;
                            OP_REAR_UP:    s.rear  = cur_i.rear + 3'd1;
                            default:       s.rear  = cur_i.rear - 3'd1;
                        endcase
                    end
                end else if (op == OP_MODE) begin
                    s.mode_auto = 1'b1;
                end else if (op == OP_HILL) begin
                    s.hill = !cur_i.hill;
                    if (s.hill) begin
                        s.front = HILL_FRONT;
                        s.rear  = HILL_REAR;
                    end
                end
            end else begin
                if (op == OP_MODE) begin
                    s.mode_auto = 1'b0;
                    s.tick      = 8'd0;
                end else if (op == OP_HILL) begin
                    s.hill = !cur_i.hill;
                    if (s.hill) begin
                        s.front = HILL_FRONT;
                        s.rear  = HILL_REAR;
                    end else begin
                        run_auto = 1'b1;
                    end
                end else begin
                    run_auto = 1'b1;
                end
            end

            // Automatic step: move the index one notch toward the tick reading.
            if (run_auto && s.pending) begin
                idx_a  = (cur_i.tick == 8'd0) ? idx_sat : cur_i.index;
                s.tick = item_i.tire_ticks;
                if (item_i.cadence <= cfg_i.auto_min) begin
                    s.warning = 1'b1;
                    s.index   = idx_a;
                end else begin
                    s.warning = 1'b0;
                    if (item_i.tire_ticks > {3'd0, idx_a} && idx_a <= STEP_UP_MAX) begin
                        idx_b   = idx_a + IDX_W'(1);
                        s.index = idx_b;
                        s.front = FRONT_TAB[idx_b];
                        s.rear  = REAR_TAB[idx_b];
                    end else if (item_i.tire_ticks < {3'd0, idx_a} && idx_a >= STEP_DOWN_MIN) begin
                        idx_b   = idx_a - IDX_W'(1);
                        s.index = idx_b;
                        s.front = FRONT_TAB[idx_b];
                        s.rear  = REAR_TAB[idx_b];
                    end else begin
                        s.index   = idx_a;
                        s.pending = 1'b0;
                    end
                end
            end
        end

        nxt_o     = s;
        shifted_o = (s.front != cur_i.front) || (s.rear != cur_i.rear);
    end

endmodule

>>> sv/gear_shift_controller.sv
`timescale 1ns / 1ps

// Gear shift controller for a bicycle drivetrain.
//
// Input channel (s_*): one control word per event: button opcode, wheel speed,
// pedal cadence, tire tick reading and a new-data pulse. Result channel (m_*):
// one word per event with the commanded front/rear gears, a shifted flag, the
// low cadence warning, the auto mode and hill flags and the power state.
// Configuration channel (cfg_*): always ready; index 0/1 load the initial
// front/rear gear (and the live gear with it), 2/3 the manual and automatic
// cadence thresholds. Write configuration only while no word is in flight.
//
// From input accept to result valid, the word sits in the input register; the
// edge that advances it applies the gear state update and loads the result
// register.
// Throughput is one word per cycle; both registers advance together, so a
// steady stream with m_ready high sees no bubbles.
// When the receiver stalls, the result register holds, the input register
// takes one more word and then s_ready drops until the result is taken.
// Reset (aresetn low, synchronous) empties both registers, restores the
// configuration defaults and starts in manual mode with front 1 / rear 6.
module gear_shift_controller #(
    parameter int TABLE_DEPTH = gsc_pkg::TABLE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_opcode,
    input  logic [7:0] s_speed,
    input  logic [7:0] s_cadence,
    input  logic [7:0] s_tire_ticks,
    input  logic       s_new_data,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_front_gear,
    output logic [2:0] m_rear_gear,
    output logic       m_shifted,
    output logic       m_low_cadence_warning,
    output logic       m_auto_mode,
    output logic       m_hill_active,
    output logic       m_power_state,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import gsc_pkg::*;

    localparam int IDX_LIM_INT = (TABLE_DEPTH - 1 > 31) ? 31 : TABLE_DEPTH - 1;
    localparam logic [IDX_W-1:0] IDX_LIM = IDX_W'(IDX_LIM_INT);

    logic       in_valid_reg;
    gsc_item_t  in_item_reg;
    logic       out_valid_reg;
    gsc_state_t out_state_reg;
    logic       out_shifted_reg;

    gsc_state_t state_reg;
    gsc_state_t state_next;
    gsc_cfg_t   cfg_reg;
    logic       step_shifted;
    logic       step_store;

    logic advance;
    logic s_fire;
    logic cfg_fire;

    // Advance the input word into the result register when the slot frees up.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    gsc_step #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_step (
        .cur_i         (state_reg),
        .cfg_i         (cfg_reg),
        .item_i        (in_item_reg),
        .nxt_o         (state_next),
        .shifted_o     (step_shifted),
        .store_gears_o (step_store)
    );

    // Handshake control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= '{opcode:     s_opcode,
                             speed:      s_speed,
                             cadence:    s_cadence,
                             tire_ticks: s_tire_ticks,
                             new_data:   s_new_data};
        end
        if (advance) begin
            out_state_reg   <= state_next;
            out_shifted_reg <= step_shifted;
        end
    end

    // Gear state and configuration. A gear load from the config port wins
    // over the step; the two never meet in legal use.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg   <= '{init_front: INIT_FRONT_RST,
                           init_rear:  INIT_REAR_RST,
                           man_min:    MAN_MIN_RST,
                           auto_min:   AUTO_MIN_RST};
            state_reg <= '{halted: 1'b0, mode_auto: 1'b0, hill: 1'b0, warning: 1'b0,
                           pending: 1'b0, tick: 8'd0, index: '0,
                           front: INIT_FRONT_RST, rear: INIT_REAR_RST};
        end else begin
            if (advance) begin
                state_reg <= state_next;
                if (step_store) begin
                    // Save the live gears to the stored initial gears on shutdown.
                    cfg_reg.init_front <= state_reg.front;
                    cfg_reg.init_rear  <= state_reg.rear;
                end
            end
            if (cfg_fire) begin
                unique case (gsc_cfg_idx_t'(cfg_index))
                    CFG_INIT_FRONT: begin
                        cfg_reg.init_front <= cfg_data[1:0];
                        state_reg.front    <= cfg_data[1:0];
                    end
                    CFG_INIT_REAR: begin
                        cfg_reg.init_rear <= cfg_data[2:0];
                        state_reg.rear    <= cfg_data[2:0];
                    end
                    CFG_MAN_MIN:  cfg_reg.man_min  <= cfg_data;
                    CFG_AUTO_MIN: cfg_reg.auto_min <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_front_gear          = out_state_reg.front;
    assign m_rear_gear           = out_state_reg.rear;
    assign m_shifted             = out_shifted_reg;
    assign m_low_cadence_warning = out_state_reg.warning;
    assign m_auto_mode           = out_state_reg.mode_auto;
    assign m_hill_active         = out_state_reg.hill;
    assign m_power_state         = out_state_reg.halted;

    // Once halted, stay halted until reset.
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.halted |=> state_reg.halted)
        else $error("halted state cleared without reset");

    // A powered-down result never reports a gear change.
    a_halt_no_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_state_reg.halted) |-> !out_shifted_reg)
        else $error("shift reported while powered down");

    // The shift index never leaves the table range.
    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.index <= IDX_LIM)
        else $error("shift index beyond table limit");

    // A stalled result freezes the gear state unless a configuration write lands.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && !cfg_fire) |=> $stable(state_reg))
        else $error("gear state moved while result stalled");

endmodule
